[rtl/core/triangle_face_normal_macros.svh]
// ----------------------------------------------------------------------------
// triangle_face_normal_macros
// Assertion helpers used by triangle_face_normal.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TFN_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TFN_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and constants of the triangle face normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  localparam int COORD_W   = 16;
  localparam int IDX_W     = 10;
  localparam int VERT_W    = 3 * COORD_W;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int CROSS_W   = 35;
  localparam int MAG_W     = 31;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = 64;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int T2_W      = 30;
  localparam int CMP_W     = 96;
  localparam int Q_W       = 15;
  localparam int BIT_W     = 4;
  localparam int OUT_W     = 16;
  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 48;

  // input tdata layout
  localparam int SLOT_LSB = 0;
  localparam int X_LSB    = 10;
  localparam int Y_LSB    = 26;
  localparam int Z_LSB    = 42;
  localparam int A_LSB    = 58;
  localparam int B_LSB    = 68;
  localparam int C_LSB    = 78;

  localparam logic [Q_W-1:0]   Q_ONE    = 15'd16384;
  localparam logic [BIT_W-1:0] TOP_BIT  = 4'd14;
  localparam logic             KIND_VERTEX = 1'b0;
  localparam logic             KIND_FACE   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_LOAD,
    ST_CROSS,
    ST_MAG,
    ST_SQ,
    ST_CHECK,
    ST_T,
    ST_LO,
    ST_HI,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

endpackage

`default_nettype wire

[rtl/core/triangle_face_normal.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal
// Vertex store plus unit normal of a triangle (cross product / length, Q1.14).
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser       tlast
// s_axis   in   slot,x,y,z,corner_a,corner_b,corner_c   kind        final_face
// m_axis   out  unit_x,unit_y,unit_z                    degenerate  final_normal
//
// Vertex transaction: stored if slot < MAX_VERTICES; the input stays ready.
// Face transaction: three store reads, six cross-product terms, three squares
//   and a 15-bit search per component, all on one shared 32x32 multiplier.
//   One face at a time.
// A finished normal waits in the output register; the next transaction is
//   taken meanwhile. The store has no reset and is never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
  input  logic [tfn_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // unit_x, unit_y, unit_z
  output logic [tfn_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // degenerate
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  import tfn_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  state_t state, state_next;

  // input fields
  logic [IDX_W-1:0] in_slot, in_a, in_b, in_c;
  vertex_t          in_vert;
  logic             in_acc, vert_acc, face_acc, slot_ok;

  // store
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [VERT_W-1:0] ram_rdata;

  // face registers
  logic [AW-1:0] a_addr, b_addr, c_addr;
  logic          a_ok, b_ok, c_ok, final_r;
  vertex_t       va, vb, vc;

  // arithmetic
  logic [2:0]                 cnt;
  logic [2:0]                 cm1;
  logic signed [CROSS_W-1:0]  n_vec [3];
  logic [MAG_W-1:0]           m_vec [3];
  logic                       sgn [3];
  logic [SQ_W-1:0]            msq [3];
  logic [SUM_W-1:0]           s;
  logic [MUL_W-1:0]           mul_a, mul_b;
  logic [PROD_W-1:0]          p;
  logic                       mul_neg, mul_neg_in;
  logic [T2_W-1:0]            t2;
  logic [PROD_W-1:0]          plo;
  logic [Q_W-1:0]             q, cand, q_new;
  logic [BIT_W-1:0]           bit_idx;
  logic [1:0]                 comp;
  logic [OUT_W-1:0]           res [3];
  logic                       degen;
  logic                       skip, pass;

  // output register
  logic                  out_valid, load_out;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_degen, out_last;

  // edges and cross-product operands
  logic signed [EDGE_W-1:0] x1, y1, z1, x2, y2, z2, op_l, op_r;
  logic [EDGE_W-1:0]        mag_l, mag_r;
  logic [CROSS_W-1:0]       mag_n [3];
  logic [CROSS_W-1:0]       big;
  logic [1:0]               kshift;
  logic [CROSS_W-1:0]       term;
  logic [CMP_W-1:0]         lhs, rhs;
  logic [Q_W:0]             tval;

  assign in_slot = s_axis_tdata[SLOT_LSB +: IDX_W];
  assign in_vert.x = s_axis_tdata[X_LSB +: COORD_W];
  assign in_vert.y = s_axis_tdata[Y_LSB +: COORD_W];
  assign in_vert.z = s_axis_tdata[Z_LSB +: COORD_W];
  assign in_a = s_axis_tdata[A_LSB +: IDX_W];
  assign in_b = s_axis_tdata[B_LSB +: IDX_W];
  assign in_c = s_axis_tdata[C_LSB +: IDX_W];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign vert_acc = in_acc && (s_axis_tuser == KIND_VERTEX);
  assign face_acc = in_acc && (s_axis_tuser == KIND_FACE);
  assign slot_ok  = 32'(in_slot) < 32'(MAX_VERTICES);

  tfn_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_vert),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = AW'(32'(in_slot));

  // edge vectors E1 = A - B, E2 = B - C
  assign x1 = EDGE_W'(va.x) - EDGE_W'(vb.x);
  assign y1 = EDGE_W'(va.y) - EDGE_W'(vb.y);
  assign z1 = EDGE_W'(va.z) - EDGE_W'(vb.z);
  assign x2 = EDGE_W'(vb.x) - EDGE_W'(vc.x);
  assign y2 = EDGE_W'(vb.y) - EDGE_W'(vc.y);
  assign z2 = EDGE_W'(vb.z) - EDGE_W'(vc.z);

  always_comb begin
    case (cnt)
      3'd0:    begin op_l = y1; op_r = z2; end
      3'd1:    begin op_l = y2; op_r = z1; end
      3'd2:    begin op_l = z1; op_r = x2; end
      3'd3:    begin op_l = z2; op_r = x1; end
      3'd4:    begin op_l = x1; op_r = y2; end
      default: begin op_l = x2; op_r = y1; end
    endcase
  end

  assign mag_l = op_l[EDGE_W-1] ? EDGE_W'(-op_l) : EDGE_W'(op_l);
  assign mag_r = op_r[EDGE_W-1] ? EDGE_W'(-op_r) : EDGE_W'(op_r);
  assign cm1   = cnt - 3'd1;
  assign term  = mul_neg ? CROSS_W'(0) - CROSS_W'(p) : CROSS_W'(p);

  // magnitudes and the common right shift that brings them below 2^31
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_n[i] = n_vec[i][CROSS_W-1] ? CROSS_W'(-n_vec[i]) : CROSS_W'(n_vec[i]);
    end
    big = mag_n[0];
    if (mag_n[1] > big) big = mag_n[1];
    if (mag_n[2] > big) big = mag_n[2];
    if (big[CROSS_W-1:32] != '0)      kshift = 2'd2;
    else if (big[31])                 kshift = 2'd1;
    else                              kshift = 2'd0;
  end

  // search step: largest q with (2q-1)^2 * S <= m^2 * 2^30
  assign cand  = q | (Q_W'(1) << bit_idx);
  assign skip  = cand > Q_ONE;
  assign tval  = {cand, 1'b0} - (Q_W+1)'(1);
  assign lhs   = {p, 32'd0} + CMP_W'(plo);
  assign rhs   = CMP_W'({msq[comp], 30'd0});
  assign pass  = lhs <= rhs;
  assign q_new = (state == ST_CMP && pass) ? cand : q;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (face_acc) state_next = ST_RD_A;
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_RD_C;
      ST_RD_C:  state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_CROSS;
      ST_CROSS: if (cnt == 3'd6) state_next = ST_MAG;
      ST_MAG:   state_next = ST_SQ;
      ST_SQ:    if (cnt == 3'd3) state_next = ST_CHECK;
      ST_CHECK: state_next = (s == '0) ? ST_DONE : ST_T;
      ST_T: begin
        if (!skip) state_next = ST_LO;
        else if (bit_idx == '0 && comp == 2'd2) state_next = ST_DONE;
      end
      ST_LO:    state_next = ST_HI;
      ST_HI:    state_next = ST_CMP;
      ST_CMP:   state_next = (bit_idx == '0 && comp == 2'd2) ? ST_DONE : ST_T;
      ST_DONE:  if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = a_addr;
    mul_a         = '0;
    mul_b         = '0;
    mul_neg_in    = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = vert_acc && slot_ok;
      end
      ST_RD_A: ram_raddr = a_addr;
      ST_RD_B: ram_raddr = b_addr;
      ST_RD_C: ram_raddr = c_addr;
      ST_CROSS: begin
        mul_a      = MUL_W'(mag_l);
        mul_b      = MUL_W'(mag_r);
        mul_neg_in = op_l[EDGE_W-1] ^ op_r[EDGE_W-1] ^ cnt[0];
      end
      ST_SQ: begin
        if (cnt < 3'd3) begin
          mul_a = MUL_W'(m_vec[cnt[1:0]]);
          mul_b = MUL_W'(m_vec[cnt[1:0]]);
        end
      end
      ST_T: begin
        mul_a = MUL_W'(tval);
        mul_b = MUL_W'(tval);
      end
      ST_LO: begin
        mul_a = MUL_W'(p[T2_W-1:0]);
        mul_b = s[MUL_W-1:0];
      end
      ST_HI: begin
        mul_a = MUL_W'(t2);
        mul_b = s[SUM_W-1:MUL_W];
      end
      ST_DONE: load_out = !out_valid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p       <= mul_a * mul_b;
    mul_neg <= mul_neg_in;
    case (state)
      ST_IDLE: begin
        if (face_acc) begin
          a_addr  <= AW'(32'(in_a));
          b_addr  <= AW'(32'(in_b));
          c_addr  <= AW'(32'(in_c));
          a_ok    <= 32'(in_a) < 32'(MAX_VERTICES);
          b_ok    <= 32'(in_b) < 32'(MAX_VERTICES);
          c_ok    <= 32'(in_c) < 32'(MAX_VERTICES);
          final_r <= s_axis_tlast;
        end
      end
      ST_RD_B: va <= a_ok ? vertex_t'(ram_rdata) : '0;
      ST_RD_C: vb <= b_ok ? vertex_t'(ram_rdata) : '0;
      ST_LOAD: begin
        vc  <= c_ok ? vertex_t'(ram_rdata) : '0;
        cnt <= '0;
      end
      ST_CROSS: begin
        cnt <= cnt + 3'd1;
        // product of the step before lands here; odd steps subtract
        if (cnt != '0) begin
          if (!cm1[0]) n_vec[cm1[2:1]] <= term;
          else         n_vec[cm1[2:1]] <= n_vec[cm1[2:1]] + term;
        end
      end
      ST_MAG: begin
        for (int i = 0; i < 3; i++) begin
          m_vec[i] <= MAG_W'(mag_n[i] >> kshift);
          sgn[i]   <= n_vec[i][CROSS_W-1];
        end
        s   <= '0;
        cnt <= '0;
      end
      ST_SQ: begin
        cnt <= cnt + 3'd1;
        if (cnt != '0) begin
          msq[cm1[1:0]] <= p[SQ_W-1:0];
          s             <= s + p;
        end
      end
      ST_CHECK: begin
        degen   <= s == '0;
        q       <= '0;
        bit_idx <= TOP_BIT;
        comp    <= '0;
        for (int i = 0; i < 3; i++) res[i] <= '0;
      end
      ST_LO: t2  <= p[T2_W-1:0];
      ST_HI: plo <= p;
      ST_T, ST_CMP: begin
        if (state == ST_CMP || skip) begin
          if (bit_idx == '0) begin
            res[comp] <= sgn[comp] ? OUT_W'(0) - OUT_W'(q_new) : OUT_W'(q_new);
            comp      <= comp + 2'd1;
            q         <= '0;
            bit_idx   <= TOP_BIT;
          end else begin
            q       <= q_new;
            bit_idx <= bit_idx - BIT_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_data  <= {res[2], res[1], res[0]};
          out_degen <= degen;
          out_last  <= final_r;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_degen;
  assign m_axis_tlast  = out_last;

  `include "triangle_face_normal_macros.svh"

  `TFN_ASSERT_NXT(a_face_starts, clk, rst, face_acc, state == ST_RD_A, "face did not start")
  `TFN_ASSERT_NXT(a_done_loads, clk, rst, state == ST_DONE && !out_valid, out_valid, "no result")
  `TFN_ASSERT_IMP(a_degen_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "degenerate not zero")
  `TFN_ASSERT_IMP(a_q_range, clk, rst, state == ST_T || state == ST_CMP, q <= Q_ONE, "q above one")

endmodule

`default_nettype wire

[rtl/core/tfn_ram.sv]
// ----------------------------------------------------------------------------
// tfn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks triangle_face_normal. Vertex transactions fill a local copy of the
// store; face transactions are scored against a local exact-rounding normal
// calculation. The sender and the receiver both stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tfn_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    degenerate;
    logic                    last;
  } normal_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  vertex_t  mesh_store [1024];
  bit       slot_written [1024];
  int       written_slots [$];
  normal_t  pending_normals [$];
  int       error_count;
  bit       calm;
  int       rx_hold;

  triangle_face_normal u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // exact rounded unit normal of triangle a, b, c
  function automatic normal_t face_normal(vertex_t va, vertex_t vb, vertex_t vc,
                                          logic last);
    longint     x1, y1, z1, x2, y2, z2;
    longint     n [3];
    bit [63:0]  mag [3];
    bit [63:0]  biggest;
    bit [63:0]  sum_sq;
    bit [127:0] lhs, rhs;
    bit [63:0]  t;
    int         lo, hi, mid, k;
    logic [OUT_W-1:0] comp [3];
    normal_t    r;
    x1 = longint'(va.x) - longint'(vb.x);
    y1 = longint'(va.y) - longint'(vb.y);
    z1 = longint'(va.z) - longint'(vb.z);
    x2 = longint'(vb.x) - longint'(vc.x);
    y2 = longint'(vb.y) - longint'(vc.y);
    z2 = longint'(vb.z) - longint'(vc.z);
    n[0] = y1 * z2 - y2 * z1;
    n[1] = z1 * x2 - z2 * x1;
    n[2] = x1 * y2 - x2 * y1;
    biggest = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
      if (mag[i] > biggest) biggest = mag[i];
    end
    k = 0;
    while ((biggest >> k) >= (64'd1 << 31)) k++;
    sum_sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> k;
      sum_sq += mag[i] * mag[i];
    end
    r.last = last;
    if (sum_sq == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0;
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      lo = 0;
      hi = 16384;
      rhs = 128'(mag[i] * mag[i]) << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 64'(2 * mid - 1);
        lhs = 128'(t * t) * 128'(sum_sq);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      comp[i] = (n[i] < 0) ? OUT_W'(-lo) : OUT_W'(lo);
    end
    r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2];
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // one transaction on the input side, predicted when accepted
  task automatic send_item(logic kind, logic [9:0] slot, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z, logic [9:0] a,
                           logic [9:0] b, logic [9:0] c, logic last);
    int gap;
    vertex_t v;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {c, b, a, z, y, x, slot};
    do @(posedge clk); while (!s_axis_tready);
    if (kind == KIND_VERTEX) begin
      v.x = x; v.y = y; v.z = z;
      mesh_store[slot] = v;
      if (!slot_written[slot]) written_slots.push_back(slot);
      slot_written[slot] = 1'b1;
    end else begin
      pending_normals.push_back(face_normal(mesh_store[a], mesh_store[b],
                                            mesh_store[c], last));
    end
  endtask

  task automatic put_vertex(int slot, int x, int y, int z);
    send_item(KIND_VERTEX, 10'(slot), 16'(x), 16'(y), 16'(z), 10'($urandom),
              10'($urandom), 10'($urandom), 1'($urandom));
  endtask

  task automatic put_face(int a, int b, int c, bit last);
    send_item(KIND_FACE, 10'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 10'(a), 10'(b), 10'(c), last);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_slot();
    return written_slots[$urandom_range(0, written_slots.size() - 1)];
  endfunction

  function automatic int rand_coord(bit tiny);
    if (tiny) return $urandom_range(0, 15) - 8;
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic test_directed();
    put_vertex(0, 0, 0, 0);
    put_vertex(1023, -32768, -32768, -32768);
    put_vertex(1, 32767, 0, 0);
    put_vertex(2, 0, 32767, 0);
    put_vertex(3, 0, 0, 32767);
    put_vertex(4, 32767, 32767, 32767);
    put_vertex(5, -32768, 32767, -32768);
    put_vertex(6, 4096, 4096, 4096);
    put_vertex(7, 1, 0, 0);
    put_vertex(8, 0, 1, 0);
    put_face(0, 0, 0, 1'b0);       // same corner three times
    put_face(0, 6, 4, 1'b0);       // collinear corners
    put_face(0, 1, 2, 1'b0);
    put_face(2, 0, 1, 1'b0);
    put_face(0, 2, 3, 1'b0);
    put_face(1023, 4, 5, 1'b0);    // largest cross product
    put_face(4, 1023, 1, 1'b0);
    put_face(0, 7, 8, 1'b0);       // smallest nonzero cross product
    put_face(5, 1, 1023, 1'b1);
    put_vertex(8, 32767, -32768, 1);  // overwrite a slot
    put_face(7, 8, 0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_mesh(int count);
    bit tiny;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      tiny = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0)
        put_vertex($urandom_range(0, 1023), rand_coord(tiny), rand_coord(tiny),
                   rand_coord(tiny));
      else if ($urandom_range(0, 15) == 0)
        put_face(pick_slot(), pick_slot(), pick_slot(), 1'($urandom));
      else
        put_face(pick_slot(), pick_slot(), pick_slot(), ($urandom_range(0, 9) == 0));
    end
    calm = 1'b0;
  endtask

  // result side: random stalls, then score the transaction
  always @(posedge clk) begin
    normal_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_normals.size() == 0) begin
          report_mismatch("unexpected normal", 1, 0);
        end else begin
          want = pending_normals.pop_front();
          if ($signed(m_axis_tdata[15:0]) != want.nx)
            report_mismatch("unit_x", $signed(m_axis_tdata[15:0]), want.nx);
          if ($signed(m_axis_tdata[31:16]) != want.ny)
            report_mismatch("unit_y", $signed(m_axis_tdata[31:16]), want.ny);
          if ($signed(m_axis_tdata[47:32]) != want.nz)
            report_mismatch("unit_z", $signed(m_axis_tdata[47:32]), want.nz);
          if (m_axis_tuser != want.degenerate)
            report_mismatch("degenerate", m_axis_tuser, want.degenerate);
          if (m_axis_tlast != want.last)
            report_mismatch("final_normal", m_axis_tlast, want.last);
        end
        rx_hold = calm ? 0 : $urandom_range(0, 19);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      m_axis_tready <= (rx_hold == 0);
    end
  end

  initial begin
    error_count   = 0;
    calm          = 1'b0;
    rx_hold       = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mesh(450);
    wait_drained();
    test_random_mesh(480);
    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
